// File: rtl/nsrmv_pkg.sv
package nsrmv_pkg;

    // cell store geometry
    localparam int CELL_COUNT = 4096;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int CELL_IDX_W = 12;

    // field widths
    localparam int DATA_W = 32;
    localparam int VAR_W  = 64;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // beta divider: 48-bit divisor, 32 quotient bits, one bit per cycle
    localparam int DIV_W     = 48;
    localparam int QUOT_W    = 32;
    localparam int DIV_STEPS = QUOT_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    // shared multiplier operands and product
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ITERATION_MODE   = 1'b0,
        REG_AVERAGING_WINDOW = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0]        elapsed;
        logic [DATA_W-1:0]        count;
        logic signed [DATA_W-1:0] mean;
        logic signed [VAR_W-1:0]  variance;
    } t_cell_rec;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: rtl/nsrmv_div.sv
// Restoring divider: quotient of (num * 2^32) / den, num < den, one bit per cycle.
module nsrmv_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nsrmv_pkg::t_div_req i_req,
    output nsrmv_pkg::t_div_rsp o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [nsrmv_pkg::DIV_CW-1:0]       r_cnt;
    logic [nsrmv_pkg::DIV_W-1:0]        r_rem;
    logic [nsrmv_pkg::DIV_W-1:0]        r_den;
    logic [nsrmv_pkg::QUOT_W-1:0]       r_quot;

    logic [nsrmv_pkg::DIV_W:0]          shifted;
    logic [nsrmv_pkg::DIV_W+1:0]        trial;
    logic                               ge;
    logic [nsrmv_pkg::DIV_W-1:0]        n_rem;

    always_comb begin
        shifted = {r_rem, 1'b0};
        trial   = {1'b0, shifted} - {2'b00, r_den};
        ge      = !trial[nsrmv_pkg::DIV_W+1];
        n_rem   = ge ? trial[nsrmv_pkg::DIV_W-1:0] : shifted[nsrmv_pkg::DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= nsrmv_pkg::DIV_CW'(nsrmv_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - nsrmv_pkg::DIV_CW'(1);
                if (r_cnt == nsrmv_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[nsrmv_pkg::QUOT_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// File: rtl/nsrmv_mul.sv
// Shared signed multiplier with a registered product.
module nsrmv_mul (
    input  logic                                i_clk,
    input  logic signed [nsrmv_pkg::MUL_W-1:0]  i_a,
    input  logic signed [nsrmv_pkg::MUL_W-1:0]  i_b,
    output logic signed [nsrmv_pkg::PROD_W-1:0] o_p
);

    logic signed [nsrmv_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: rtl/nonzero_sample_running_mean_variance.sv
// Per-cell running mean (Q16.16) and mean-square deviation (Q32.32) that skips
// zero samples. Each accepted word names a cell, a signed Q16.16 sample and an
// unsigned Q16.16 time step, and yields exactly one result word with the cell's
// mean and variance after the update (was_updated low when the sample is zero or
// the cell is out of range). After reset the block sweeps its cell store to zero,
// one cell per cycle, through all CELL_COUNT (4096) cells before it takes the first
// word; configuration writes are taken at any time. Between the accept of a nonzero
// sample and the next ready, the 32-step restoring divider forms beta and the
// multiply steps follow on one shared 34x34 multiplier. When beta saturates at
// one the divider is skipped; a zero sample skips both. The result sits in an
// output register, so the next word may enter while a result waits to be taken.
module nonzero_sample_running_mean_variance (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [nsrmv_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [nsrmv_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input words
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [nsrmv_pkg::CELL_IDX_W-1:0]       i_cell_index,
    input  logic signed [nsrmv_pkg::DATA_W-1:0]    i_sample,
    input  logic [nsrmv_pkg::DATA_W-1:0]           i_time_step,
    // result words
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [nsrmv_pkg::CELL_IDX_W-1:0]       o_cell_number,
    output logic signed [nsrmv_pkg::DATA_W-1:0]    o_mean_value,
    output logic signed [nsrmv_pkg::VAR_W-1:0]     o_variance_value,
    output logic                                   o_was_updated
);

    localparam int DW  = nsrmv_pkg::DATA_W;
    localparam int VW  = nsrmv_pkg::VAR_W;
    localparam int QW  = nsrmv_pkg::QUOT_W;
    localparam int AW  = nsrmv_pkg::CELL_AW;
    localparam int MW  = nsrmv_pkg::MUL_W;
    localparam int XW  = nsrmv_pkg::DIV_W;
    localparam logic [QW:0] BETA_ONE = {1'b1, {QW{1'b0}}};
    // unit step of iteration mode, 1.0 in Q16.16
    localparam logic [XW-1:0] UNIT_STEP = XW'(32'h0001_0000);

    typedef enum logic [16:0] {
        S_CLR    = 17'h00001,
        S_IDLE   = 17'h00002,
        S_LOAD   = 17'h00004,
        S_PREP   = 17'h00008,
        S_DSTART = 17'h00010,
        S_DWAIT  = 17'h00020,
        S_BETA   = 17'h00040,
        S_M1     = 17'h00080,
        S_M2     = 17'h00100,
        S_M3     = 17'h00200,
        S_M4     = 17'h00400,
        S_M5     = 17'h00800,
        S_M6     = 17'h01000,
        S_M7     = 17'h02000,
        S_M8     = 17'h04000,
        S_M9     = 17'h08000,
        S_FIN    = 17'h10000
    } t_state;

    function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        logic signed [VW-1:0] s;
        s = a + b;
        if ((a[VW-1] == b[VW-1]) && (s[VW-1] != a[VW-1])) begin
            s = a[VW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
        return s;
    endfunction

    // control
    t_state                          r_state;
    t_state                          n_state;
    logic [AW-1:0]                   r_clr_addr;
    logic                            r_iter_mode;
    logic [DW-1:0]                   r_avg_window;
    logic                            r_out_valid;

    // item payload and working registers
    logic [nsrmv_pkg::CELL_IDX_W-1:0] r_cell;
    logic signed [DW-1:0]            r_x;
    logic [DW-1:0]                   r_tstep;
    logic [DW-1:0]                   r_et;
    logic [DW-1:0]                   r_cnt;
    logic signed [DW-1:0]            r_mean;
    logic signed [DW-1:0]            r_mnew;
    logic signed [DW:0]              r_diff;
    logic signed [VW-1:0]            r_acc;
    logic signed [VW-1:0]            r_tmp;
    logic [XW-1:0]                   r_step;
    logic [XW-1:0]                   r_dv;
    logic                            r_one;
    logic [QW:0]                     r_beta;
    logic [QW:0]                     r_wgt;
    logic                            r_upd;

    // result register
    logic [nsrmv_pkg::CELL_IDX_W-1:0] r_out_cell;
    logic signed [DW-1:0]            r_out_mean;
    logic signed [VW-1:0]            r_out_var;
    logic                            r_out_upd;

    // cell store
    nsrmv_pkg::t_cell_rec            r_mem [nsrmv_pkg::CELL_COUNT];
    nsrmv_pkg::t_cell_rec            r_rd;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    nsrmv_pkg::t_cell_rec            mem_wdata;

    logic                            in_fire;
    logic                            in_range;
    logic                            out_free;
    logic                            fin_fire;

    logic [DW:0]                     et_sum;
    logic [DW-1:0]                   et_new;
    logic [DW-1:0]                   cnt_new;

    logic [XW-1:0]                   step_sel;
    logic [XW-1:0]                   div_sel;
    logic [XW-1:0]                   win_ext;
    logic [XW:0]                     slack;
    logic                            win_hit;
    logic                            one_d;
    logic                            one_w;

    logic signed [MW-1:0]            mul_a;
    logic signed [MW-1:0]            mul_b;
    logic signed [nsrmv_pkg::PROD_W-1:0] mul_p;

    nsrmv_pkg::t_div_req             div_req;
    nsrmv_pkg::t_div_rsp             div_rsp;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_cell_index) < 32'(nsrmv_pkg::CELL_COUNT));
    assign out_free   = !r_out_valid || i_out_ready;
    assign fin_fire   = (r_state == S_FIN) && out_free;

    // elapsed time and count saturate at all ones
    always_comb begin
        et_sum  = {1'b0, r_rd.elapsed} + {1'b0, r_tstep};
        et_new  = et_sum[DW] ? {DW{1'b1}} : et_sum[DW-1:0];
        cnt_new = (&r_rd.count) ? r_rd.count : r_rd.count + DW'(1);
    end

    // pick step and divisor; the window replaces the divisor once enough has gone by
    always_comb begin
        step_sel = r_iter_mode ? UNIT_STEP : {{(XW-DW){1'b0}}, r_tstep};
        div_sel  = r_iter_mode ? {r_cnt, {(XW-DW){1'b0}}} : {{(XW-DW){1'b0}}, r_et};
        win_ext  = {{(XW-DW){1'b0}}, r_avg_window};
        slack    = {1'b0, div_sel} - {1'b0, step_sel};
        win_hit  = (r_avg_window != '0) && !slack[XW] && (slack[XW-1:0] >= win_ext);
        one_d    = (div_sel == '0) || (step_sel >= div_sel);
        one_w    = (step_sel >= win_ext);
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_PREP: begin
                mul_a = {{(MW-DW){r_mean[DW-1]}}, r_mean};
                mul_b = {{(MW-DW){r_mean[DW-1]}}, r_mean};
            end
            S_M1: begin
                mul_a = {{(MW-DW-1){r_diff[DW]}}, r_diff};
                mul_b = {{(MW-QW-1){1'b0}}, r_beta};
            end
            S_M2: begin
                mul_a = {{(MW-DW){r_acc[VW-1]}}, r_acc[VW-1:DW]};
                mul_b = {{(MW-QW-1){1'b0}}, r_wgt};
            end
            S_M3: begin
                mul_a = {{(MW-DW){1'b0}}, r_acc[DW-1:0]};
                mul_b = {{(MW-QW-1){1'b0}}, r_wgt};
            end
            S_M4: begin
                mul_a = {{(MW-DW){r_x[DW-1]}}, r_x};
                mul_b = {{(MW-DW){r_x[DW-1]}}, r_x};
            end
            S_M5: begin
                mul_a = {{(MW-DW){1'b0}}, mul_p[VW-1:DW]};
                mul_b = {{(MW-QW-1){1'b0}}, r_beta};
            end
            S_M6: begin
                mul_a = {{(MW-DW){1'b0}}, r_tmp[DW-1:0]};
                mul_b = {{(MW-QW-1){1'b0}}, r_beta};
            end
            S_M7: begin
                mul_a = {{(MW-DW){r_mnew[DW-1]}}, r_mnew};
                mul_b = {{(MW-DW){r_mnew[DW-1]}}, r_mnew};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    nsrmv_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign div_req.start = (r_state == S_DSTART) && !r_one;
    assign div_req.num   = r_step;
    assign div_req.den   = r_dv;

    nsrmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr_addr == AW'(nsrmv_pkg::CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = in_range ? S_LOAD : S_FIN;
                end
            end
            S_LOAD:   n_state = (r_x == '0) ? S_FIN : S_PREP;
            S_PREP:   n_state = S_DSTART;
            S_DSTART: n_state = r_one ? S_BETA : S_DWAIT;
            S_DWAIT: begin
                if (div_rsp.done) begin
                    n_state = S_BETA;
                end
            end
            S_BETA:   n_state = S_M1;
            S_M1:     n_state = S_M2;
            S_M2:     n_state = S_M3;
            S_M3:     n_state = S_M4;
            S_M4:     n_state = S_M5;
            S_M5:     n_state = S_M6;
            S_M6:     n_state = S_M7;
            S_M7:     n_state = S_M8;
            S_M8:     n_state = S_M9;
            S_M9:     n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_addr   <= '0;
            r_iter_mode  <= 1'b0;
            r_avg_window <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                case (nsrmv_pkg::t_reg_idx'(i_cfg_index))
                    nsrmv_pkg::REG_ITERATION_MODE:   r_iter_mode  <= i_cfg_data[0];
                    nsrmv_pkg::REG_AVERAGING_WINDOW: r_avg_window <= i_cfg_data[DW-1:0];
                    default: ;
                endcase
            end
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: a product issued in one step is consumed in the next
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_cell  <= i_cell_index;
                    r_x     <= i_sample;
                    r_tstep <= i_time_step;
                    // out-of-range cells report zeros
                    r_mnew  <= '0;
                    r_acc   <= '0;
                    r_upd   <= 1'b0;
                end
            end
            S_LOAD: begin
                r_et   <= et_new;
                r_cnt  <= cnt_new;
                r_mean <= r_rd.mean;
                r_mnew <= r_rd.mean;
                r_acc  <= r_rd.variance;
                r_upd  <= (r_x != '0);
            end
            S_PREP: begin
                r_step <= step_sel;
                r_dv   <= win_hit ? win_ext : div_sel;
                r_one  <= win_hit ? one_w : one_d;
                r_diff <= {r_x[DW-1], r_x} - {r_mean[DW-1], r_mean};
            end
            S_DSTART: begin
                // add the old mean squared back in
                r_acc <= sat_add(r_acc, mul_p[VW-1:0]);
            end
            S_BETA: begin
                r_beta <= r_one ? BETA_ONE : {1'b0, div_rsp.quot};
                r_wgt  <= r_one ? '0 : BETA_ONE - {1'b0, div_rsp.quot};
            end
            S_M2: begin
                // mean + floor(beta * (x - mean) / 2^32); exact modulo 2^32
                r_mnew <= r_mean + mul_p[VW-1:DW];
            end
            S_M3: r_tmp <= mul_p[VW-1:0];
            S_M4: r_acc <= r_tmp + {{DW{1'b0}}, mul_p[VW-1:DW]};
            S_M5: r_tmp <= mul_p[VW-1:0];
            S_M6: r_tmp <= mul_p[VW-1:0];
            S_M7: r_tmp <= r_tmp + {{DW{1'b0}}, mul_p[VW-1:DW]};
            S_M8: begin
                r_acc <= sat_add(r_acc, r_tmp);
                r_tmp <= mul_p[VW-1:0];
            end
            S_M9: r_acc <= sat_add(r_acc, -r_tmp);
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_out_cell <= r_cell;
            r_out_mean <= r_mnew;
            r_out_var  <= r_acc;
            r_out_upd  <= r_upd;
        end
    end

    // cell store: clearing sweep after reset, write back on finish
    always_comb begin
        mem_we    = (r_state == S_CLR) || (fin_fire && r_upd);
        mem_waddr = (r_state == S_CLR) ? r_clr_addr : r_cell[AW-1:0];
        if (r_state == S_CLR) begin
            mem_wdata = '0;
        end else begin
            mem_wdata.elapsed  = r_et;
            mem_wdata.count    = r_cnt;
            mem_wdata.mean     = r_mnew;
            mem_wdata.variance = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[i_cell_index[AW-1:0]];
    end

    assign o_out_valid      = r_out_valid;
    assign o_cell_number    = r_out_cell;
    assign o_mean_value     = r_out_mean;
    assign o_variance_value = r_out_var;
    assign o_was_updated    = r_out_upd;

endmodule
